### design/mcbp_pkg.sv
// mcbp_pkg: shared types and codes for the multi-channel byte pipe
// request and response words, command and status codes, default sizes
// no dependencies
`default_nettype none

package mcbp_pkg;

    localparam int DEF_NUM_PIPES  = 4;
    localparam int DEF_PIPE_DEPTH = 8;

    localparam logic [1:0] CMD_OPEN  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_OPEN = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NO_FREE  = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] pipe_index;
        logic [7:0] write_byte;
        logic       last_of_transfer;
    } t_req_word;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_byte;
        logic [1:0] opened_pipe;
        logic       transfer_done;
    } t_rsp_word;

endpackage

`default_nettype wire

### design/mcbp_byte_ram.sv
// mcbp_byte_ram: byte store shared by all pipes
// one write port, one read port with registered read data
// no dependencies
`default_nettype none

module mcbp_byte_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/multi_channel_byte_pipe.sv
// multi_channel_byte_pipe: set of ring-buffer byte pipes with open/write/read commands
// uses mcbp_pkg and mcbp_byte_ram
// o_done marks the result in S_REPLY, entered from S_EXEC after the accepting edge
// busy is high in S_EXEC, which writes the descriptor back; a new word can be accepted
//   in S_REPLY while the previous result is shown
// reset: open flags and control cleared, byte store and descriptors not cleared
// the receiver cannot stall; each result is shown for one cycle only
`default_nettype none

module multi_channel_byte_pipe
    import mcbp_pkg::*;
#(
    parameter int NUM_PIPES  = DEF_NUM_PIPES,
    parameter int PIPE_DEPTH = DEF_PIPE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_req_word i_req,
    output logic           o_done,
    output t_rsp_word      o_rsp
);

    localparam int PW     = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int PTR_W  = $clog2(PIPE_DEPTH);
    localparam int CNT_W  = $clog2(PIPE_DEPTH + 1);
    localparam int RAM_AW = PW + PTR_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_REPLY = 2'd2;

    typedef struct packed {
        logic [PTR_W-1:0] wr_ptr;
        logic [PTR_W-1:0] rd_ptr;
        logic [CNT_W-1:0] count;
    } t_desc;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    t_req_word            r_req;
    t_desc                r_desc_mem [NUM_PIPES];
    t_desc                r_desc_q;
    logic [NUM_PIPES-1:0] r_pipe_open;
    logic [2:0]           r_status;
    logic [2:0]           n_status;
    logic [1:0]           r_opened;
    logic [1:0]           n_opened;
    logic                 r_rd_ok;
    logic                 n_rd_ok;

    logic                 accept;
    logic [PW-1:0]        in_addr;
    logic [PW-1:0]        req_addr;
    logic                 req_in_range;
    logic                 req_open;
    logic                 free_found;
    logic [PW-1:0]        free_idx;
    logic                 desc_we;
    logic [PW-1:0]        desc_waddr;
    t_desc                desc_wdata;
    logic                 open_set;
    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic                 ram_re;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [7:0]           ram_q;

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;

    assign in_addr      = PW'(i_req.pipe_index);
    assign req_addr     = PW'(r_req.pipe_index);
    assign req_in_range = (32'(r_req.pipe_index) < NUM_PIPES);
    assign req_open     = req_in_range ? r_pipe_open[req_addr] : 1'b0;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        advance = (ptr == PTR_W'(PIPE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!r_pipe_open[i]) begin
                free_found = 1'b1;
                free_idx   = PW'(i);
            end
        end
    end

    always_comb begin
        n_status   = ST_OK;
        n_opened   = '0;
        n_rd_ok    = 1'b0;
        desc_we    = 1'b0;
        desc_waddr = req_addr;
        desc_wdata = r_desc_q;
        open_set   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = {req_addr, r_desc_q.wr_ptr};
        ram_re     = 1'b0;
        ram_raddr  = {req_addr, r_desc_q.rd_ptr};
        if (r_state == S_EXEC) begin
            unique case (r_req.cmd)
                CMD_OPEN: begin
                    if (free_found) begin
                        open_set   = 1'b1;
                        desc_we    = 1'b1;
                        desc_waddr = free_idx;
                        desc_wdata = '0;
                        n_opened   = 2'(free_idx);
                    end else begin
                        n_status = ST_NO_FREE;
                    end
                end
                CMD_WRITE: begin
                    if (!req_open) begin
                        n_status = ST_NOT_OPEN;
                    end else if (r_desc_q.count == CNT_W'(PIPE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we            = 1'b1;
                        desc_we           = 1'b1;
                        desc_wdata.wr_ptr = advance(r_desc_q.wr_ptr);
                        desc_wdata.count  = r_desc_q.count + CNT_W'(1);
                    end
                end
                CMD_READ: begin
                    if (!req_open) begin
                        n_status = ST_NOT_OPEN;
                    end else if (r_desc_q.count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ram_re            = 1'b1;
                        n_rd_ok           = 1'b1;
                        desc_we           = 1'b1;
                        desc_wdata.rd_ptr = advance(r_desc_q.rd_ptr);
                        desc_wdata.count  = r_desc_q.count - CNT_W'(1);
                    end
                end
                CMD_NOP: begin
                    n_status = ST_OK;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_REPLY;
            S_REPLY: n_state = accept ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pipe_open <= '0;
        end else begin
            r_state <= n_state;
            if (open_set) begin
                r_pipe_open[free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req;
            r_desc_q <= r_desc_mem[in_addr];
        end
        if (desc_we) begin
            r_desc_mem[desc_waddr] <= desc_wdata;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_opened <= n_opened;
            r_rd_ok  <= n_rd_ok;
        end
    end

    mcbp_byte_ram #(
        .DATA_W (8),
        .ADDR_W (RAM_AW)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (r_req.write_byte),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_q)
    );

    assign o_done              = (r_state == S_REPLY);
    assign o_rsp.status        = r_status;
    assign o_rsp.read_byte     = r_rd_ok ? ram_q : 8'd0;
    assign o_rsp.opened_pipe   = r_opened;
    assign o_rsp.transfer_done = r_req.last_of_transfer;

endmodule

`default_nettype wire

### dv/tb.sv
// tb: self-checking testbench for multi_channel_byte_pipe
// a table of directed words runs first, then random bursts; each result is compared with the table's
// fixed word if it has one, else a local pipe predictor. depends on mcbp_pkg and the design sources
`timescale 1ns / 100ps

module tb;
    import mcbp_pkg::*;

    localparam int NPIPE        = DEF_NUM_PIPES;
    localparam int DEPTH        = DEF_PIPE_DEPTH;
    localparam int RANDOM_WORDS = 1700;
    localparam int CYCLE_LIMIT  = 100000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_req_word req_word;
    logic      o_done;
    t_rsp_word rsp_word;

    multi_channel_byte_pipe u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req_word),
        .o_done  (o_done),
        .o_rsp   (rsp_word)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // predictor state
    logic       pipe_claimed [NPIPE];
    int         wr_ptr       [NPIPE];
    int         rd_ptr       [NPIPE];
    int         fill_level   [NPIPE];
    logic [7:0] pipe_bytes   [NPIPE][DEPTH];

    t_rsp_word  pending_rsp_q [$];
    t_req_word  step_req_q    [$];
    bit         step_typed_q  [$];
    t_rsp_word  step_rsp_q    [$];

    int         words_sent;
    int         words_checked;
    int         fail_count;
    int         cycle_count;
    int         status_seen [8];
    t_rsp_word  want;

    function automatic int ring_next(input int ptr);
        return (ptr + 1 >= DEPTH) ? 0 : ptr + 1;
    endfunction

    function automatic t_rsp_word next_pipe_response(input t_req_word w);
        t_rsp_word r;
        logic      found;
        int        p;
        r = '0;
        r.status = ST_OK;
        r.transfer_done = w.last_of_transfer;
        found = 1'b0;
        p = int'(w.pipe_index);
        case (w.cmd)
            CMD_OPEN: begin
                for (int i = 0; i < NPIPE; i++) begin
                    if (!found && !pipe_claimed[i]) begin
                        pipe_claimed[i] = 1'b1;
                        wr_ptr[i] = 0;
                        rd_ptr[i] = 0;
                        fill_level[i] = 0;
                        r.opened_pipe = 2'(i);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_NO_FREE;
                end
            end
            CMD_WRITE, CMD_READ: begin
                if (p >= NPIPE || !pipe_claimed[p]) begin
                    r.status = ST_NOT_OPEN;
                end else if (w.cmd == CMD_WRITE) begin
                    if (fill_level[p] >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        pipe_bytes[p][wr_ptr[p]] = w.write_byte;
                        wr_ptr[p] = ring_next(wr_ptr[p]);
                        fill_level[p]++;
                    end
                end else begin
                    if (fill_level[p] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.read_byte = pipe_bytes[p][rd_ptr[p]];
                        rd_ptr[p] = ring_next(rd_ptr[p]);
                        fill_level[p]--;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_step(input logic [1:0] cmd, input logic [1:0] idx,
                            input logic [7:0] wbyte, input logic last, input bit typed,
                            input logic [2:0] st, input logic [7:0] rbyte,
                            input logic [1:0] opened);
        t_req_word w;
        t_rsp_word r;
        w.cmd = cmd;
        w.pipe_index = idx;
        w.write_byte = wbyte;
        w.last_of_transfer = last;
        r.status = st;
        r.read_byte = rbyte;
        r.opened_pipe = opened;
        r.transfer_done = last;
        step_req_q.push_back(w);
        step_typed_q.push_back(typed);
        step_rsp_q.push_back(r);
    endtask

    task automatic issue_word(input t_req_word w, input bit typed, input t_rsp_word fixed);
        t_rsp_word predicted;
        start <= 1'b1;
        req_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = next_pipe_response(w);
        pending_rsp_q.push_back(typed ? fixed : predicted);
        words_sent++;
    endtask

    task automatic wait_for_drain();
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_rsp_q.size() == 0) begin
                $error("result word with nothing expected: %h", rsp_word);
                fail_count++;
            end else begin
                want = pending_rsp_q.pop_front();
                words_checked++;
                status_seen[rsp_word.status]++;
                if (rsp_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                    fail_count++;
                end
                if (rsp_word.read_byte !== want.read_byte) begin
                    $error("read_byte: expected %h, got %h", want.read_byte,
                           rsp_word.read_byte);
                    fail_count++;
                end
                if (rsp_word.opened_pipe !== want.opened_pipe) begin
                    $error("opened_pipe: expected %0d, got %0d", want.opened_pipe,
                           rsp_word.opened_pipe);
                    fail_count++;
                end
                if (rsp_word.transfer_done !== want.transfer_done) begin
                    $error("transfer_done: expected %0d, got %0d", want.transfer_done,
                           rsp_word.transfer_done);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_req_word w;
        int        burst_len;
        int        gap;
        int        write_pct;
        int        focus;
        int        roll;
        int        bursts;
        int        random_sent;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        req_word <= '0;
        words_sent = 0;
        words_checked = 0;
        fail_count = 0;
        random_sent = 0;
        bursts = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        foreach (pipe_claimed[k]) begin
            pipe_claimed[k] = 1'b0;
            wr_ptr[k] = 0;
            rd_ptr[k] = 0;
            fill_level[k] = 0;
        end

        // access to unopened pipes, idle command, open/write/read, empty pipe, no free pipe, full pipe
        add_step(CMD_WRITE, 2'd0, 8'h5a, 1'b0, 1, ST_NOT_OPEN, 8'h00, 2'd0);
        add_step(CMD_READ,  2'd3, 8'h00, 1'b1, 1, ST_NOT_OPEN, 8'h00, 2'd0);
        add_step(CMD_NOP,   2'd3, 8'hff, 1'b1, 1, ST_OK,       8'h00, 2'd0);
        add_step(CMD_OPEN,  2'd2, 8'haa, 1'b0, 1, ST_OK,       8'h00, 2'd0);
        add_step(CMD_READ,  2'd0, 8'h00, 1'b0, 1, ST_EMPTY,    8'h00, 2'd0);
        add_step(CMD_WRITE, 2'd0, 8'hff, 1'b1, 1, ST_OK,       8'h00, 2'd0);
        add_step(CMD_WRITE, 2'd0, 8'h00, 1'b0, 0, ST_OK,       8'h00, 2'd0);
        add_step(CMD_READ,  2'd0, 8'h00, 1'b0, 1, ST_OK,       8'hff, 2'd0);
        add_step(CMD_READ,  2'd0, 8'h00, 1'b1, 0, ST_OK,       8'h00, 2'd0);
        add_step(CMD_READ,  2'd0, 8'h00, 1'b0, 1, ST_EMPTY,    8'h00, 2'd0);
        add_step(CMD_OPEN,  2'd0, 8'h00, 1'b0, 1, ST_OK,       8'h00, 2'd1);
        add_step(CMD_WRITE, 2'd3, 8'h81, 1'b0, 1, ST_NOT_OPEN, 8'h00, 2'd0);
        add_step(CMD_OPEN,  2'd1, 8'h00, 1'b0, 1, ST_OK,       8'h00, 2'd2);
        add_step(CMD_OPEN,  2'd3, 8'h00, 1'b1, 1, ST_OK,       8'h00, 2'd3);
        add_step(CMD_OPEN,  2'd0, 8'h00, 1'b0, 1, ST_NO_FREE,  8'h00, 2'd0);
        for (int k = 0; k < DEPTH; k++) begin
            add_step(CMD_WRITE, 2'd1, 8'(8'h11 * (k + 1)), 1'(k), 0, ST_OK, 8'h00, 2'd0);
        end
        add_step(CMD_WRITE, 2'd1, 8'h7e, 1'b1, 1, ST_FULL,     8'h00, 2'd0);
        add_step(CMD_READ,  2'd1, 8'h00, 1'b0, 0, ST_OK,       8'h00, 2'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (step_req_q[k]) begin
            issue_word(step_req_q[k], step_typed_q[k], step_rsp_q[k]);
        end
        start <= 1'b0;
        wait_for_drain();

        // random bursts around one busy pipe, each burst at random mostly filling, mostly draining or mixed
        while (random_sent < RANDOM_WORDS) begin
            burst_len = $urandom_range(1, 40);
            focus = $urandom_range(0, NPIPE - 1);
            case ($urandom_range(0, 2))
                0:       write_pct = 80;
                1:       write_pct = 20;
                default: write_pct = 50;
            endcase
            for (int k = 0; k < burst_len && random_sent < RANDOM_WORDS; k++) begin
                roll = $urandom_range(0, 99);
                w.write_byte = 8'($urandom);
                w.last_of_transfer = 1'($urandom);
                w.pipe_index = ($urandom_range(0, 3) != 0) ? 2'(focus) : 2'($urandom);
                if (roll < 3) begin
                    w.cmd = CMD_NOP;
                end else if (roll < 6) begin
                    w.cmd = CMD_OPEN;
                end else if ($urandom_range(0, 99) < write_pct) begin
                    w.cmd = CMD_WRITE;
                end else begin
                    w.cmd = CMD_READ;
                end
                issue_word(w, 0, '0);
                random_sent++;
            end
            bursts++;
            if (bursts % 9 == 0) begin
                start <= 1'b0;
                wait_for_drain();
            end else if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        wait_for_drain();
        repeat (4) @(posedge i_clk);

        if (pending_rsp_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_rsp_q.size());
            fail_count++;
        end
        $display("covered %0d words in %0d random bursts, %0d results checked",
                 words_sent, bursts, words_checked);
        $display("status mix: ok %0d, not open %0d, empty %0d, full %0d, no free %0d",
                 status_seen[ST_OK], status_seen[ST_NOT_OPEN], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_NO_FREE]);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
